// File: rtl/mvt_pkg.sv
// Package for the 4x4 matrix-vector transform.
// Holds coefficient and matrix types, register indexes, reset values and lane control.
// No dependencies.
`timescale 1ns / 1ps

package mvt_pkg;

   localparam int COEF_WIDTH      = 16;
   localparam int COEF_FRAC       = 12;
   localparam int NUM_ROWS        = 4;
   localparam int NUM_COLS        = 4;
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int CSR_DATA_WIDTH  = 64;

   typedef logic signed [COEF_WIDTH-1:0] coef_type;
   typedef logic [CSR_DATA_WIDTH-1:0]    column_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_COLUMN_0 = 8'd0,
      CSR_COLUMN_1 = 8'd1,
      CSR_COLUMN_2 = 8'd2,
      CSR_COLUMN_3 = 8'd3
   } csr_index_type;

   localparam column_type IDENTITY_COLUMN_0 = 64'h0000_0000_0000_1000;
   localparam column_type IDENTITY_COLUMN_1 = 64'h0000_0000_1000_0000;
   localparam column_type IDENTITY_COLUMN_2 = 64'h0000_1000_0000_0000;
   localparam column_type IDENTITY_COLUMN_3 = 64'h1000_0000_0000_0000;

   typedef struct packed {
      logic advance_mult;
      logic advance_sum;
   } lane_ctrl_type;

endpackage

// File: rtl/mvt_interfaces.sv
// Channel interfaces of the 4x4 matrix-vector transform: request, response, register write.
// Depends on mvt_pkg.
`timescale 1ns / 1ps

interface mvt_req_if #(
   parameter int SAMPLE_WIDTH = 16
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] in_x;
   logic signed [SAMPLE_WIDTH-1:0] in_y;
   logic signed [SAMPLE_WIDTH-1:0] in_z;
   logic signed [SAMPLE_WIDTH-1:0] in_w;

   modport source (output valid, output in_x, output in_y, output in_z, output in_w,
                   input ready);
   modport sink (input valid, input in_x, input in_y, input in_z, input in_w,
                 output ready);
endinterface

interface mvt_rsp_if #(
   parameter int SAMPLE_WIDTH = 16
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] out_x;
   logic signed [SAMPLE_WIDTH-1:0] out_y;
   logic signed [SAMPLE_WIDTH-1:0] out_z;
   logic signed [SAMPLE_WIDTH-1:0] out_w;
   logic                           saturated;

   modport source (output valid, output out_x, output out_y, output out_z, output out_w,
                   output saturated, input ready);
   modport sink (input valid, input out_x, input out_y, input out_z, input out_w,
                 input saturated, output ready);
endinterface

interface mvt_csr_if;
   import mvt_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [CSR_DATA_WIDTH-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/mvt_csr.sv
// Matrix column registers of the 4x4 matrix-vector transform, reset to the identity.
// Depends on mvt_pkg and mvt_csr_if.
`timescale 1ns / 1ps

module mvt_csr
   import mvt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   mvt_csr_if.sink    csr,
   output column_type columns [NUM_COLS]
);

   column_type columns_ff [NUM_COLS];

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff[0] <= IDENTITY_COLUMN_0;
         columns_ff[1] <= IDENTITY_COLUMN_1;
         columns_ff[2] <= IDENTITY_COLUMN_2;
         columns_ff[3] <= IDENTITY_COLUMN_3;
      end else if (csr.valid) begin
         case (csr.index)
            CSR_COLUMN_0: columns_ff[0] <= csr.data;
            CSR_COLUMN_1: columns_ff[1] <= csr.data;
            CSR_COLUMN_2: columns_ff[2] <= csr.data;
            CSR_COLUMN_3: columns_ff[3] <= csr.data;
            default: ;
         endcase
      end
   end

   assign columns = columns_ff;

endmodule

// File: rtl/mvt_lane.sv
// One row lane: four coefficient-by-component products, then sum, floor shift and saturation.
// Depends on mvt_pkg.
`timescale 1ns / 1ps

module mvt_lane
   import mvt_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                           clock,
   input  lane_ctrl_type                  ctrl,
   input  coef_type                       coef [NUM_COLS],
   input  logic signed [SAMPLE_WIDTH-1:0] vec [NUM_COLS],
   output logic signed [SAMPLE_WIDTH-1:0] result,
   output logic                           clamped
);

   localparam int PROD_WIDTH  = SAMPLE_WIDTH + COEF_WIDTH;
   localparam int SUM_WIDTH   = PROD_WIDTH + 2;
   localparam int SHIFT_WIDTH = SUM_WIDTH - COEF_FRAC;
   localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   logic signed [PROD_WIDTH-1:0]   prod_ff [NUM_COLS];
   logic signed [PROD_WIDTH-1:0]   prod_in [NUM_COLS];
   logic signed [SUM_WIDTH-1:0]    sum;
   logic signed [SHIFT_WIDTH-1:0]  shifted;
   logic [SHIFT_WIDTH-SAMPLE_WIDTH:0] top_bits;
   logic                           overflow;
   logic signed [SAMPLE_WIDTH-1:0] result_ff;
   logic signed [SAMPLE_WIDTH-1:0] result_in;
   logic                           clamped_ff;

   always_comb begin
      for (int k = 0; k < NUM_COLS; k++) begin
         prod_in[k] = PROD_WIDTH'(coef[k]) * PROD_WIDTH'(vec[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance_mult) begin
         prod_ff <= prod_in;
      end
   end

   always_comb begin
      sum = SUM_WIDTH'(prod_ff[0]) + SUM_WIDTH'(prod_ff[1])
          + SUM_WIDTH'(prod_ff[2]) + SUM_WIDTH'(prod_ff[3]);
      shifted  = sum[SUM_WIDTH-1:COEF_FRAC];
      top_bits = shifted[SHIFT_WIDTH-1:SAMPLE_WIDTH-1];
      overflow = !((&top_bits) || !(|top_bits));
      if (overflow) begin
         result_in = shifted[SHIFT_WIDTH-1] ? SAT_MIN : SAT_MAX;
      end else begin
         result_in = shifted[SAMPLE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance_sum) begin
         result_ff  <= result_in;
         clamped_ff <= overflow;
      end
   end

   assign result  = result_ff;
   assign clamped = clamped_ff;

endmodule

// File: rtl/mvt_merge.sv
// Merge stage: registers the four lane results and combines the lane clamp flags.
// Depends on mvt_pkg.
`timescale 1ns / 1ps

module mvt_merge
   import mvt_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           load,
   input  logic signed [SAMPLE_WIDTH-1:0] lane_result [NUM_ROWS],
   input  logic                           lane_clamped [NUM_ROWS],
   output logic signed [SAMPLE_WIDTH-1:0] out_x,
   output logic signed [SAMPLE_WIDTH-1:0] out_y,
   output logic signed [SAMPLE_WIDTH-1:0] out_z,
   output logic signed [SAMPLE_WIDTH-1:0] out_w,
   output logic                           saturated
);

   logic signed [SAMPLE_WIDTH-1:0] out_ff [NUM_ROWS];
   logic                           saturated_ff;
   logic                           saturated_in;

   always_comb begin
      saturated_in = 1'b0;
      for (int r = 0; r < NUM_ROWS; r++) begin
         saturated_in = saturated_in | lane_clamped[r];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff       <= lane_result;
         saturated_ff <= saturated_in;
      end
   end

   assign out_x     = out_ff[0];
   assign out_y     = out_ff[1];
   assign out_z     = out_ff[2];
   assign out_w     = out_ff[3];
   assign saturated = saturated_ff;

endmodule

// File: rtl/matrix_vector_transform_4x4_top.sv
// Top level of the 4x4 matrix-vector transform: four row lanes, merge stage and pipeline control.
// Depends on mvt_pkg, the channel interfaces, mvt_csr, mvt_lane and mvt_merge.
//
//   Channel  Direction  Payload                              Transfer
//   req      in         in_x, in_y, in_z, in_w               valid && ready
//   rsp      out        out_x, out_y, out_z, out_w, saturated valid && ready
//   csr      in         index, data (64-bit matrix column)   valid && ready
//
// One request per clock while the response channel is not stalled; each response passes
// through the multiply stage, sum and saturate stage, and output register in that order.
// Reset is synchronous and loads the identity matrix; the pipeline empties at once.
// A stalled response holds the output register; earlier stages keep filling their bubbles.
`timescale 1ns / 1ps

module matrix_vector_transform_4x4_top
   import mvt_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   mvt_req_if.sink   req,
   mvt_rsp_if.source rsp,
   mvt_csr_if.sink   csr
);

   column_type                     columns [NUM_COLS];
   logic signed [SAMPLE_WIDTH-1:0] vec [NUM_COLS];
   coef_type                       row_coef [NUM_ROWS][NUM_COLS];
   logic signed [SAMPLE_WIDTH-1:0] lane_result [NUM_ROWS];
   logic                           lane_clamped [NUM_ROWS];
   lane_ctrl_type                  lane_ctrl;

   logic mult_valid_ff;
   logic sum_valid_ff;
   logic rsp_valid_ff;
   logic advance_mult;
   logic advance_sum;
   logic advance_out;

   mvt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr     (csr),
      .columns (columns)
   );

   assign vec[0] = req.in_x;
   assign vec[1] = req.in_y;
   assign vec[2] = req.in_z;
   assign vec[3] = req.in_w;

   always_comb begin
      for (int r = 0; r < NUM_ROWS; r++) begin
         for (int k = 0; k < NUM_COLS; k++) begin
            row_coef[r][k] = columns[k][COEF_WIDTH*r +: COEF_WIDTH];
         end
      end
   end

   assign advance_out  = !rsp_valid_ff || rsp.ready;
   assign advance_sum  = !sum_valid_ff || advance_out;
   assign advance_mult = !mult_valid_ff || advance_sum;

   assign req.ready = advance_mult;
   assign rsp.valid = rsp_valid_ff;

   assign lane_ctrl.advance_mult = advance_mult;
   assign lane_ctrl.advance_sum  = advance_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         mult_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (advance_mult) begin
            mult_valid_ff <= req.valid;
         end
         if (advance_sum) begin
            sum_valid_ff <= mult_valid_ff;
         end
         if (advance_out) begin
            rsp_valid_ff <= sum_valid_ff;
         end
      end
   end

   for (genvar r = 0; r < NUM_ROWS; r++) begin : g_lane
      mvt_lane #(
         .SAMPLE_WIDTH (SAMPLE_WIDTH)
      ) u_lane (
         .clock   (clock),
         .ctrl    (lane_ctrl),
         .coef    (row_coef[r]),
         .vec     (vec),
         .result  (lane_result[r]),
         .clamped (lane_clamped[r])
      );
   end

   mvt_merge #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_merge (
      .clock        (clock),
      .load         (advance_out),
      .lane_result  (lane_result),
      .lane_clamped (lane_clamped),
      .out_x        (rsp.out_x),
      .out_y        (rsp.out_y),
      .out_z        (rsp.out_z),
      .out_w        (rsp.out_w),
      .saturated    (rsp.saturated)
   );

   localparam logic signed [SAMPLE_WIDTH-1:0] CHK_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] CHK_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   a_accept_fills_mult: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> mult_valid_ff)
      else $error("Accepted request did not reach the multiply stage.");

   a_mult_holds: assert property (@(posedge clock) disable iff (reset)
      (mult_valid_ff && !advance_sum) |=> mult_valid_ff)
      else $error("Blocked multiply stage lost its request.");

   a_sum_to_out: assert property (@(posedge clock) disable iff (reset)
      (sum_valid_ff && advance_out) |=> rsp_valid_ff)
      else $error("Finished sum did not reach the output register.");

   a_saturated_clamps: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp.saturated) |->
         (rsp.out_x == CHK_MAX || rsp.out_x == CHK_MIN ||
          rsp.out_y == CHK_MAX || rsp.out_y == CHK_MIN ||
          rsp.out_z == CHK_MAX || rsp.out_z == CHK_MIN ||
          rsp.out_w == CHK_MAX || rsp.out_w == CHK_MIN))
      else $error("Saturation flagged without a clamped component.");

endmodule
